[design/csem_pkg.sv]
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants for the counting semaphore with wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

  localparam int unsigned ID_WIDTH      = 8;
  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned WAITERS_WIDTH = 5;
  localparam int unsigned STATUS_WIDTH  = 3;
  localparam int unsigned QUEUE_DEPTH   = 16;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - ID_WIDTH - COUNT_WIDTH - WAITERS_WIDTH;

  typedef enum logic {
    OP_DOWN = 1'b0,
    OP_UP   = 1'b1
  } op_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_GRANTED     = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_WOKEN       = 3'd2,
    ST_INCREMENTED = 3'd3,
    ST_ERROR       = 3'd4
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [ID_WIDTH-1:0] id;
  } item_t;

endpackage

`default_nettype wire

[design/csem_front.sv]
// ----------------------------------------------------------------------------
// csem_front
// Takes operations from the input stream, decodes the kind and buffers them
// in a two-entry queue toward the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [csem_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] requester_id
  input  wire logic                             s_axis_tuser,  // [0] operation
  output logic                                  item_valid_o,
  input  wire logic                             item_ready_i,
  output csem_pkg::item_t                       item_o
);

  localparam int unsigned QDEPTH = 2;

  csem_pkg::item_t buf_q [QDEPTH];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;
  csem_pkg::item_t in_item;

  always_comb begin
    in_item.op = s_axis_tuser ? csem_pkg::OP_UP : csem_pkg::OP_DOWN;
    in_item.id = s_axis_tdata[csem_pkg::ID_WIDTH-1:0];
  end

  assign s_axis_tready = (cnt_q != 2'(QDEPTH));
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = buf_q[rd_ptr_q];

  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

[design/csem_back.sv]
// ----------------------------------------------------------------------------
// csem_back
// Executes semaphore operations: count update, wait queue push/pop and the
// registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_back #(
  parameter int unsigned QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [csem_pkg::COUNT_WIDTH-1:0]   cfg_count_i,
  input  wire logic                               item_valid_i,
  output logic                                    item_ready_o,
  input  wire csem_pkg::item_t                    item_i,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] woken_id, [23:8] count_now, [28:24] waiters_now, [31:29] zero
  output logic [csem_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic [csem_pkg::STATUS_WIDTH-1:0]       m_axis_tuser  // [2:0] status
);

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDW    = csem_pkg::ID_WIDTH;
  localparam int unsigned CW     = csem_pkg::COUNT_WIDTH;
  localparam int unsigned WW     = csem_pkg::WAITERS_WIDTH;

  localparam logic BK_EXEC = 1'b0;
  localparam logic BK_WAKE = 1'b1;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [IDW-1:0]    wq_mem [QUEUE_DEPTH];
  logic [IDW-1:0]    rd_q;

  logic              state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  logic              wq_we;
  logic              res_fire;
  logic              out_free;
  csem_pkg::status_e res_status;
  logic [IDW-1:0]    res_woken;
  logic [FILL_W+WW-1:0] fill_ext;

  logic              out_valid_q;
  csem_pkg::status_e out_status_q;
  logic [IDW-1:0]    out_woken_q;
  logic [CW-1:0]     out_count_q;
  logic [WW-1:0]     out_waiters_q;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    item_ready_o = 1'b0;
    res_fire     = 1'b0;
    res_status   = csem_pkg::ST_GRANTED;
    res_woken    = '0;
    wq_we        = 1'b0;

    unique case (state_q)
      BK_EXEC: begin
        if (item_valid_i && out_free) begin
          if (item_i.op == csem_pkg::OP_DOWN) begin
            item_ready_o = 1'b1;
            res_fire     = 1'b1;
            priority if (count_q != '0) begin
              count_d    = count_q - CW'(1);
              res_status = csem_pkg::ST_GRANTED;
            end else if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
              res_status = csem_pkg::ST_ERROR;
            end else begin
              wq_we      = 1'b1;
              tail_d     = next_ptr(tail_q);
              fill_d     = fill_q + FILL_W'(1);
              res_status = csem_pkg::ST_QUEUED;
            end
          end else if (fill_q != '0) begin
            // head entry is read into rd_q on this edge
            state_d = BK_WAKE;
          end else begin
            item_ready_o = 1'b1;
            res_fire     = 1'b1;
            if (&count_q) begin
              res_status = csem_pkg::ST_ERROR;
            end else begin
              count_d    = count_q + CW'(1);
              res_status = csem_pkg::ST_INCREMENTED;
            end
          end
        end
      end
      BK_WAKE: begin
        if (out_free) begin
          item_ready_o = 1'b1;
          res_fire     = 1'b1;
          res_status   = csem_pkg::ST_WOKEN;
          res_woken    = rd_q;
          head_d       = next_ptr(head_q);
          fill_d       = fill_q - FILL_W'(1);
          state_d      = BK_EXEC;
        end
      end
    endcase

    // register write acts as creation; the user must write only while idle, the block does not enforce it
    if (cfg_we_i) begin
      count_d = cfg_count_i;
      head_d  = '0;
      tail_d  = '0;
      fill_d  = '0;
      state_d = BK_EXEC;
    end
  end

  assign fill_ext = {{WW{1'b0}}, fill_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EXEC;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_status_q  <= res_status;
      out_woken_q   <= res_woken;
      out_count_q   <= count_d;
      out_waiters_q <= fill_ext[WW-1:0];
    end
  end

  // wait queue storage
  always_ff @(posedge clk_i) begin
    if (wq_we) begin
      wq_mem[tail_q] <= item_i.id;
    end
    rd_q <= wq_mem[head_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{csem_pkg::OUT_PAD_W{1'b0}}, out_waiters_q, out_count_q, out_woken_q};

endmodule

`default_nettype wire

[design/counting_semaphore_fifo_core.sv]
// Path: an accepted operation is registered in the two-entry input buffer, then
// executed into the registered result stage; a wake also passes the wake state,
// which reads the wait queue memory. Throughput: 1 operation per cycle while results
// are taken; an up that wakes a waiter blocks the next one during the wake state.
// Reset: count 0, wait queue empty, no result pending; a register write
// reloads the count and empties the queue.
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_core
// Counting semaphore with a FIFO of waiting requester IDs, stream interface.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_fifo_core #(
  parameter int unsigned QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [csem_pkg::COUNT_WIDTH-1:0]    cfg_data_i,     // initial_count
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [csem_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [7:0] requester_id
  input  wire logic                                s_axis_tuser,   // [0] operation
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] woken_id, [23:8] count_now, [28:24] waiters_now, [31:29] zero
  output logic [csem_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic [csem_pkg::STATUS_WIDTH-1:0]        m_axis_tuser    // [2:0] status
);

  logic            item_valid;
  logic            item_ready;
  csem_pkg::item_t item;

  assign cfg_ready_o = 1'b1;

  csem_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  csem_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_count_i   (cfg_data_i),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

[design/csem_checker.sv]
// ----------------------------------------------------------------------------
// csem_port_checks
// Port-level checks for the counting semaphore core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_port_checks (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [csem_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic [csem_pkg::STATUS_WIDTH-1:0]   m_axis_tuser
);

  logic [csem_pkg::COUNT_WIDTH-1:0]   count_now;
  logic [csem_pkg::WAITERS_WIDTH-1:0] waiters_now;

  assign count_now   = m_axis_tdata[csem_pkg::ID_WIDTH +: csem_pkg::COUNT_WIDTH];
  assign waiters_now =
    m_axis_tdata[csem_pkg::ID_WIDTH + csem_pkg::COUNT_WIDTH +: csem_pkg::WAITERS_WIDTH];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // requesters are only queued at a zero count
  a_queued_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == csem_pkg::ST_QUEUED) |-> (count_now == '0))
    else $error("queued with nonzero count");

  // a wake leaves the count at zero
  a_woken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == csem_pkg::ST_WOKEN) |-> (count_now == '0))
    else $error("wake with nonzero count");

  // errors only at an empty or saturated count
  a_error_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == csem_pkg::ST_ERROR) |->
      ((count_now == '0) || (&count_now)))
    else $error("error status with count in range");

  // grant or increment never coexist with waiters
  a_no_waiters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == csem_pkg::ST_GRANTED) ||
                      (m_axis_tuser == csem_pkg::ST_INCREMENTED)) |-> (waiters_now == '0))
    else $error("grant or increment with waiters queued");

endmodule

bind counting_semaphore_fifo_core csem_port_checks u_csem_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[bench/csem_checker.sv]
// ----------------------------------------------------------------------------
// csem_checker
// Watches the register, operation and result channels of the semaphore core.
// Keeps its own count and waiter FIFO, predicts the outcome of each operation
// and compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module csem_checker
  import csem_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [COUNT_WIDTH-1:0]    cfg_data_i,
  input  logic                      op_valid_i,
  input  logic                      op_ready_i,
  input  logic [IN_TDATA_W-1:0]     op_data_i,     // [7:0] requester_id
  input  logic                      op_user_i,     // [0] operation
  input  logic                      res_valid_i,
  input  logic                      res_ready_i,
  input  logic [OUT_TDATA_W-1:0]    res_data_i,    // [7:0] woken_id, [23:8] count, [28:24] waiters
  input  logic [STATUS_WIDTH-1:0]   res_user_i,    // [2:0] status
  output int unsigned               mismatch_count_o,
  output int unsigned               pending_o,
  output logic [4:0][15:0]          status_tally_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct {
    logic [STATUS_WIDTH-1:0]  status;
    logic [ID_WIDTH-1:0]      woken_id;
    logic [COUNT_WIDTH-1:0]   count_now;
    logic [WAITERS_WIDTH-1:0] waiters_now;
  } sem_outcome_t;

  logic [COUNT_WIDTH-1:0]   init_count;
  logic [COUNT_WIDTH-1:0]   avail_count;
  logic [ID_WIDTH-1:0]      waiter_ids [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wait_head;
  logic [PTR_W-1:0]         wait_tail;
  logic [WAITERS_WIDTH-1:0] wait_fill;

  sem_outcome_t expected_outcomes [$];
  int unsigned  mismatches;
  int unsigned  results_seen;

  assign mismatch_count_o = mismatches;

  // creation: load the count, drop every waiter
  function automatic void reload_semaphore();
    avail_count = init_count;
    wait_head   = '0;
    wait_tail   = '0;
    wait_fill   = '0;
  endfunction

  function automatic sem_outcome_t apply_sem_op(input op_e op, input logic [ID_WIDTH-1:0] id);
    sem_outcome_t r;
    r.woken_id = '0;
    if (op == OP_DOWN) begin
      if (avail_count != '0) begin
        avail_count = avail_count - 1'b1;
        r.status    = ST_GRANTED;
      end else if (wait_fill == QUEUE_DEPTH) begin
        r.status = ST_ERROR;
      end else begin
        waiter_ids[wait_tail] = id;
        wait_tail = wait_tail + 1'b1;
        wait_fill = wait_fill + 1'b1;
        r.status  = ST_QUEUED;
      end
    end else begin
      // waiters are served before the count moves
      if (wait_fill != '0) begin
        r.woken_id = waiter_ids[wait_head];
        wait_head  = wait_head + 1'b1;
        wait_fill  = wait_fill - 1'b1;
        r.status   = ST_WOKEN;
      end else if (avail_count == '1) begin
        r.status = ST_ERROR;
      end else begin
        avail_count = avail_count + 1'b1;
        r.status    = ST_INCREMENTED;
      end
    end
    r.count_now   = avail_count;
    r.waiters_now = wait_fill;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("checker: result %0d %s expected 0x%0h got 0x%0h",
                 results_seen, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sem_outcome_t want;
    sem_outcome_t got;
    if (!rst_ni) begin
      init_count = '0;
      reload_semaphore();
      expected_outcomes.delete();
      status_tally_o = '0;
      pending_o <= 0;
    end else begin
      // results first: a result never belongs to an operation taken at the same edge
      if (res_valid_i && res_ready_i) begin
        got.status      = res_user_i;
        got.woken_id    = res_data_i[ID_WIDTH-1:0];
        got.count_now   = res_data_i[ID_WIDTH +: COUNT_WIDTH];
        got.waiters_now = res_data_i[ID_WIDTH+COUNT_WIDTH +: WAITERS_WIDTH];
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected result, status %0d count %0d",
                     got.status, got.count_now);
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("woken_id", 32'(want.woken_id), 32'(got.woken_id));
          check_field("count_now", 32'(want.count_now), 32'(got.count_now));
          check_field("waiters_now", 32'(want.waiters_now), 32'(got.waiters_now));
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        init_count = cfg_data_i;
        reload_semaphore();
      end
      if (op_valid_i && op_ready_i) begin
        want = apply_sem_op(op_e'(op_user_i), op_data_i[ID_WIDTH-1:0]);
        status_tally_o[want.status] = status_tally_o[want.status] + 1'b1;
        expected_outcomes.push_back(want);
      end
      pending_o <= expected_outcomes.size();
    end
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the counting semaphore core: a directed pass over grant, queue,
// wake, increment, full-queue and saturation cases, then random operation
// streams under several initial counts, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csem_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 6;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic [COUNT_WIDTH-1:0]   cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]    s_axis_tdata  = '0;   // [7:0] requester_id
  logic                     s_axis_tuser  = 1'b0; // [0] operation
  logic                     m_axis_tready = 1'b0;
  wire logic                cfg_ready_o;
  wire logic                s_axis_tready;
  wire logic                m_axis_tvalid;
  wire logic [OUT_TDATA_W-1:0]  m_axis_tdata;     // [7:0] woken, [23:8] count, [28:24] waiters
  wire logic [STATUS_WIDTH-1:0] m_axis_tuser;     // [2:0] status

  int unsigned      mismatch_count;
  int unsigned      pending_results;
  logic [4:0][15:0] status_tally;

  int unsigned burst_left     = 0;
  bit          steady_send    = 1'b0;
  bit          hold_off_req   = 1'b0;
  int unsigned ops_sent       = 0;
  int unsigned settings_used  = 0;
  int unsigned idle_cycles    = 0;

  counting_semaphore_fifo_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  csem_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .op_valid_i       (s_axis_tvalid),
    .op_ready_i       (s_axis_tready),
    .op_data_i        (s_axis_tdata),
    .op_user_i        (s_axis_tuser),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_user_i       (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results),
    .status_tally_o   (status_tally)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one operation transaction; bursts of random length separated by random gaps
  task automatic push_op(input op_e op, input logic [ID_WIDTH-1:0] id);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (steady_send) gap = 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    ops_sent++;
  endtask

  // stop offering and wait until every predicted result has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_initial_count(input logic [COUNT_WIDTH-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // result side: segments of steady, loose and tight backpressure, plus one long hold-off
  initial begin
    int unsigned kind;
    int unsigned seg_len;
    int unsigned k;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        for (k = 0; k < HOLD_OFF_CYCLES; k++) begin
          @(posedge clk_i);
          m_axis_tready <= 1'b0;
        end
        hold_off_req = 1'b0;
      end else begin
        kind    = $urandom_range(0, 9);
        seg_len = $urandom_range(10, 60);
        for (k = 0; k < seg_len && !hold_off_req; k++) begin
          @(posedge clk_i);
          case (kind)
            0, 1, 2, 3: m_axis_tready <= 1'b1;
            4, 5, 6:    m_axis_tready <= 1'($urandom_range(0, 1));
            7, 8:       m_axis_tready <= ($urandom_range(0, 5) == 0);
            default:    m_axis_tready <= 1'b0;
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned            i;
    int unsigned            n;
    int unsigned            up_pct;
    logic [COUNT_WIDTH-1:0] setting;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: increment, grant, fill the queue, overflow, wake, wrap, saturate
    load_initial_count('0);
    push_op(OP_UP, 8'h00);
    push_op(OP_DOWN, 8'hFF);
    for (i = 0; i < QUEUE_DEPTH; i++) push_op(OP_DOWN, 8'(i * 17));
    push_op(OP_DOWN, 8'hA5);    // queue full
    push_op(OP_UP, 8'h5A);      // oldest waiter leaves
    push_op(OP_DOWN, 8'h3C);    // tail wraps around
    load_initial_count('1);     // also drops the queued waiters
    push_op(OP_UP, 8'h01);      // count saturated
    push_op(OP_DOWN, 8'h80);
    push_op(OP_UP, 8'h7F);

    for (i = 0; i < 8; i++) begin
      case (i)
        0:       setting = '0;
        1:       setting = 16'd1;
        2:       setting = 16'd2;
        3:       setting = '1;
        4:       setting = 16'hFFFE;
        5:       setting = 16'h8000;
        6:       setting = 16'($urandom_range(0, 20));
        default: setting = 16'($urandom_range(0, 65535));
      endcase
      load_initial_count(setting);
      // low counts with down-heavy traffic keep the wait queue busy
      up_pct = (setting > 16'hFF00) ? 70 : $urandom_range(35, 60);
      for (n = 0; n < 60; n++)
        push_op(($urandom_range(1, 100) <= up_pct) ? OP_UP : OP_DOWN,
                8'($urandom_range(0, 255)));
    end

    // back-to-back input against a long output stall
    load_initial_count(16'd5);
    steady_send  = 1'b1;
    hold_off_req = 1'b1;
    for (n = 0; n < 50; n++)
      push_op(($urandom_range(0, 2) == 0) ? OP_UP : OP_DOWN, 8'($urandom_range(0, 255)));
    steady_send = 1'b0;

    settle();
    $display("run: %0d operations under %0d initial counts, one long output stall",
             ops_sent, settings_used);
    $display("run: %0d granted, %0d queued, %0d woken, %0d incremented, %0d errors",
             status_tally[ST_GRANTED], status_tally[ST_QUEUED], status_tally[ST_WOKEN],
             status_tally[ST_INCREMENTED], status_tally[ST_ERROR]);
    if (mismatch_count == 0 && pending_results == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
